FILE: hw/rtl/asfd_pkg.sv
// Package with the word types, configuration layout and codes of the shake and flip detector.
`default_nettype none

package asfd_pkg;

  // Result codes.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_FLIP  = 2'd1;
  localparam logic [1:0] EV_SHAKE = 2'd2;
  localparam logic [1:0] EV_DIZZY = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 18;
  localparam logic [CfgIndexWidth-1:0] CFG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_COOLDOWN      = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_GAP_MIN       = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_GAP_MAX       = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_THRESHOLD     = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_FLIP_LEVEL    = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [15:0]        SAMPLE_PERIOD_RST = 16'd40;
  localparam logic [15:0]        COOLDOWN_RST      = 16'd2500;
  localparam logic [15:0]        GAP_MIN_RST       = 16'd150;
  localparam logic [15:0]        GAP_MAX_RST       = 16'd800;
  localparam logic [17:0]        THRESHOLD_RST     = 18'd8192;
  localparam logic signed [15:0] FLIP_LEVEL_RST    = -16'sd3768;

  // Input word.
  typedef struct packed {
    logic [31:0]        now_ms;
    logic               read_ok;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } sample_t;

  // Result word.
  typedef struct packed {
    logic [1:0]         event_res;
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
  } result_t;

  // Configuration register set.
  typedef struct packed {
    logic [15:0]        sample_period_ms;
    logic [15:0]        cooldown_ms;
    logic [15:0]        shake_gap_min_ms;
    logic [15:0]        shake_gap_max_ms;
    logic [17:0]        shake_threshold;
    logic signed [15:0] flip_level;
  } cfg_t;

  // Detector state carried from one word to the next.
  typedef struct packed {
    logic [31:0]        last_read_time;
    logic signed [15:0] prev_accel_x;
    logic signed [15:0] prev_accel_y;
    logic signed [15:0] prev_accel_z;
    logic signed [15:0] tilt_x_reg;
    logic signed [15:0] tilt_y_reg;
    logic [31:0]        last_jolt_time;
    logic [31:0]        last_event_time;
    logic [2:0]         jolt_count;
    logic               was_flipped;
  } state_t;

  // Absolute difference of two signed 16-bit samples; it always fits in 16 bits.
  function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    logic signed [16:0] d;
    logic [16:0]        m;
    d = {a[15], a} - {b[15], b};
    m = d[16] ? (17'd0 - 17'(d)) : 17'(d);
    return m[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/accel_shake_flip_detector_unit.sv
// Top level of the accelerometer shake and flip detector.
//
// Sample words arrive on sample/sample_valid/sample_stall and each gives exactly
// one result word on result/result_valid/result_stall, in order. A word is taken
// on a rising edge with valid high and stall low on its channel.
// An accepted sample sits in the input register while the decision logic runs
// against the detector state; the state and the result register load from it
// when the result register is empty or being emptied, and the result is offered there.
// One sample per cycle is sustained while the receiver does not stall; the input
// register and the result register form a two-deep pipeline so the next sample is
// taken while a result waits. When the receiver stalls, the result holds, the
// pipeline fills and sample_stall rises once the input register is occupied as well.
// The six configuration registers are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while the block is idle, the block does not enforce it;
// unknown indexes are ignored. Synchronous reset restores the configuration
// defaults, clears the detector state and empties both pipeline registers.
`default_nettype none

module accel_shake_flip_detector_unit (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      cfg_write,
  input  wire  [asfd_pkg::CfgIndexWidth-1:0]       cfg_index,
  input  wire  [asfd_pkg::CfgDataWidth-1:0]        cfg_data,
  input  wire                                      sample_valid,
  output logic                                     sample_stall,
  input  wire  asfd_pkg::sample_t                  sample,
  output logic                                     result_valid,
  input  wire                                      result_stall,
  output asfd_pkg::result_t                        result
);
  import asfd_pkg::*;

  cfg_t       cfg;
  state_t     state;
  state_t     state_next;
  sample_t    held;
  logic       held_valid;
  logic [1:0] event_code;
  logic       advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period_ms <= SAMPLE_PERIOD_RST;
      cfg.cooldown_ms      <= COOLDOWN_RST;
      cfg.shake_gap_min_ms <= GAP_MIN_RST;
      cfg.shake_gap_max_ms <= GAP_MAX_RST;
      cfg.shake_threshold  <= THRESHOLD_RST;
      cfg.flip_level       <= FLIP_LEVEL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SAMPLE_PERIOD: cfg.sample_period_ms <= cfg_data[15:0];
        CFG_COOLDOWN:      cfg.cooldown_ms      <= cfg_data[15:0];
        CFG_GAP_MIN:       cfg.shake_gap_min_ms <= cfg_data[15:0];
        CFG_GAP_MAX:       cfg.shake_gap_max_ms <= cfg_data[15:0];
        CFG_THRESHOLD:     cfg.shake_threshold  <= cfg_data;
        CFG_FLIP_LEVEL:    cfg.flip_level       <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  // The result register can take a new word when it is empty or being emptied.
  assign advance      = !result_valid || !result_stall;
  assign sample_stall = held_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!held_valid || advance) begin
      held_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      held <= sample;
    end
  end

  asfd_eval u_eval (
    .sample     (held),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .event_code (event_code)
  );

  // Detector state and result register move together when a word leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
      if (held_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid) begin
      result.event_res <= event_code;
      result.tilt_x    <= state_next.tilt_x_reg;
      result.tilt_y    <= state_next.tilt_y_reg;
    end
  end

  // A delivered shake has always cleared the jolt count, and nothing moves while it waits.
  a_shake_clears_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_res == EV_SHAKE |-> state.jolt_count == 3'd0)
    else $error("jolt count not cleared after a shake");

  // A delivered flip leaves the detector marked as upside down.
  a_flip_sets_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_res == EV_FLIP |-> state.was_flipped)
    else $error("flip reported without the flipped flag set");

  // The count never rises past one between shakes.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    state.jolt_count == 3'd0 || state.jolt_count == 3'd1)
    else $error("jolt count out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/asfd_eval.sv
// Decision logic of the detector: next state and event code for one sample word.
`default_nettype none

module asfd_eval (
  input  wire  asfd_pkg::sample_t sample,
  input  wire  asfd_pkg::cfg_t    cfg,
  input  wire  asfd_pkg::state_t  state,
  output asfd_pkg::state_t        state_next,
  output logic [1:0]              event_code
);
  import asfd_pkg::*;

  logic [31:0] since_read;
  logic [31:0] since_event;
  logic [31:0] jolt_gap;
  logic [17:0] total;
  logic        flipped;
  logic [2:0]  count_inc;

  // Wrapping time differences and the summed jolt magnitude.
  always_comb begin
    since_read  = sample.now_ms - state.last_read_time;
    since_event = sample.now_ms - state.last_event_time;
    jolt_gap    = sample.now_ms - state.last_jolt_time;
    total       = 18'(abs_diff(sample.accel_x, state.prev_accel_x))
                + 18'(abs_diff(sample.accel_y, state.prev_accel_y))
                + 18'(abs_diff(sample.accel_z, state.prev_accel_z));
    flipped     = sample.accel_y < cfg.flip_level;
    count_inc   = state.jolt_count + 3'd1;
  end

  // Sample gating, cooldown, flip edge and jolt counting.
  always_comb begin
    state_next = state;
    event_code = EV_NONE;
    if (since_read >= {16'd0, cfg.sample_period_ms}) begin
      state_next.last_read_time = sample.now_ms;
      if (sample.read_ok) begin
        state_next.tilt_x_reg   = sample.accel_x;
        state_next.tilt_y_reg   = sample.accel_y;
        state_next.prev_accel_x = sample.accel_x;
        state_next.prev_accel_y = sample.accel_y;
        state_next.prev_accel_z = sample.accel_z;
        if (since_event >= {16'd0, cfg.cooldown_ms}) begin
          if (flipped && !state.was_flipped) begin
            state_next.was_flipped     = 1'b1;
            state_next.last_event_time = sample.now_ms;
            event_code                 = EV_FLIP;
          end else begin
            if (!flipped) begin
              state_next.was_flipped = 1'b0;
            end
            if (total > cfg.shake_threshold) begin
              if (jolt_gap > {16'd0, cfg.shake_gap_min_ms} &&
                  jolt_gap < {16'd0, cfg.shake_gap_max_ms}) begin
                state_next.jolt_count     = count_inc;
                state_next.last_jolt_time = sample.now_ms;
                // The dizzy code needs four counted jolts, which the shake reset prevents.
                if (count_inc >= 3'd4) begin
                  state_next.jolt_count      = 3'd0;
                  state_next.last_event_time = sample.now_ms;
                  event_code                 = EV_DIZZY;
                end else if (count_inc >= 3'd2) begin
                  state_next.jolt_count      = 3'd0;
                  state_next.last_event_time = sample.now_ms;
                  event_code                 = EV_SHAKE;
                end
              end else if (jolt_gap >= {16'd0, cfg.shake_gap_max_ms}) begin
                state_next.jolt_count     = 3'd1;
                state_next.last_jolt_time = sample.now_ms;
              end
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
